/* design/dlv_pkg.sv */
`timescale 1ns / 1ps

package dlv_pkg;

  // Default graph capacity
  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF = 4096;

  // Operation codes carried by an input item
  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_ADD_EDGE = 2'd1,
    OP_LEVELIZE = 2'd2,
    OP_READ     = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_BAD_EDGE = 2'd1,
    STAT_FULL     = 2'd2,
    STAT_CYCLE    = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_WIPE,
    ST_IDLE,
    ST_READ,
    ST_CNT_A,
    ST_CNT_B,
    ST_CNT_C,
    ST_SEED_A,
    ST_SEED_B,
    ST_REL_A,
    ST_REL_B,
    ST_REL_C,
    ST_LVL_END,
    ST_FIN,
    ST_RESP
  } state_e;

  // Flags from the shared edge step unit
  typedef struct packed {
    logic in_range;
    logic hit;
    logic placed;
  } step_out_t;

  // Address byte offset of the node count register
  localparam logic [2:0] ADDR_NODE_COUNT = 3'd0;

endpackage

/* design/dlv_ram.sv */
`timescale 1ns / 1ps

module dlv_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* design/dlv_step.sv */
`timescale 1ns / 1ps

module dlv_step #(
  parameter int unsigned MAX_NODES = dlv_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = dlv_pkg::MAX_EDGES_DEF,
  localparam int unsigned NODE_W = $clog2(MAX_NODES),
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1),
  localparam int unsigned FAN_W  = $clog2(MAX_EDGES + 1)
) (
  input  logic               relax_i,
  input  logic [NODE_W-1:0]  src_i,
  input  logic [NODE_W-1:0]  dst_i,
  input  logic [CNT_W-1:0]   n_i,
  input  logic [FAN_W-1:0]   fanin_i,
  input  logic [CNT_W-1:0]   level_src_i,
  input  logic [CNT_W-1:0]   lvl_i,
  output logic [FAN_W-1:0]   fanin_next_o,
  output dlv_pkg::step_out_t res_o
);

  logic in_range;
  logic live;

  // Both ends inside the nodes in use
  assign in_range = (CNT_W'(src_i) < n_i) && (CNT_W'(dst_i) < n_i);

  // Relaxation only fires from the current level onto a node still waiting
  assign live = (level_src_i == lvl_i) && (fanin_i != '0);

  // Shared increment or decrement of the fan-in count
  assign fanin_next_o = relax_i ? (fanin_i - FAN_W'(1)) : (fanin_i + FAN_W'(1));

  always_comb begin
    res_o.in_range = in_range;
    res_o.hit      = relax_i ? (in_range && live) : in_range;
    res_o.placed   = relax_i && in_range && live && (fanin_next_o == '0);
  end

endmodule

/* design/dag_levelizer.sv */
// Levelizer for a directed graph held in on-chip edge and node memories.
// Items clear the graph, add an edge, read a node level or levelize it. Levelize
// wipes the node memories, counts fan-in over the stored edges, seeds the nodes and
// relaxes the edges once per level, one edge at a time via the shared step unit.
// One item at a time; the next is taken once the result has left or is leaving.
// After reset a wipe of all three node memories runs before the first item.
`timescale 1ns / 1ps

module dag_levelizer #(
  parameter int unsigned MAX_NODES = dlv_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = dlv_pkg::MAX_EDGES_DEF,
  localparam int unsigned NODE_W  = $clog2(MAX_NODES),
  localparam int unsigned CNT_W   = $clog2(MAX_NODES + 1),
  localparam int unsigned EDGE_AW = $clog2(MAX_EDGES),
  localparam int unsigned EDGE_CW = $clog2(MAX_EDGES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // APB configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Input items
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        operation_i,
  input  logic [NODE_W-1:0] from_node_i,
  input  logic [NODE_W-1:0] to_node_i,
  // Result items
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [1:0]        status_o,
  output logic [CNT_W-1:0]  node_level_o,
  output logic [CNT_W-1:0]  level_total_o,
  output logic [CNT_W-1:0]  sink_total_o,
  output logic [CNT_W-1:0]  placed_total_o
);

  localparam logic [CNT_W-1:0] NOT_PLACED = CNT_W'(MAX_NODES);

  dlv_pkg::state_e  state_q, state_d;
  dlv_pkg::op_e     op_q, op_d, op_in;
  dlv_pkg::status_e status_q, status_d;
  logic              boot_q, boot_d;
  logic [NODE_W-1:0] idx_q, idx_d;
  logic [EDGE_AW-1:0] edge_idx_q, edge_idx_d;
  logic [EDGE_CW-1:0] edge_total_q, edge_total_d;
  logic [CNT_W-1:0]  lvl_q, lvl_d;
  logic [CNT_W-1:0]  next_cnt_q, next_cnt_d;
  logic [CNT_W-1:0]  levels_q, levels_d;
  logic [CNT_W-1:0]  sinks_q, sinks_d;
  logic [CNT_W-1:0]  placed_q, placed_d;
  logic [CNT_W-1:0]  node_level_q, node_level_d;
  logic              out_valid_q, out_valid_d;
  logic [CNT_W-1:0]  node_count_q;
  logic [CNT_W-1:0]  n;

  // Memory ports
  logic                edge_we, edge_re;
  logic [EDGE_AW-1:0]  edge_waddr, edge_raddr;
  logic [2*NODE_W-1:0] edge_wdata, edge_rdata;
  logic                fan_we, fan_re;
  logic [NODE_W-1:0]   fan_waddr, fan_raddr;
  logic [EDGE_CW-1:0]  fan_wdata, fan_rdata;
  logic                out_we, out_re;
  logic [NODE_W-1:0]   out_waddr, out_raddr;
  logic                out_wdata, out_rdata;
  logic                lev_we, lev_re;
  logic [NODE_W-1:0]   lev_waddr, lev_raddr;
  logic [CNT_W-1:0]    lev_wdata, lev_rdata;

  // Step unit
  logic [NODE_W-1:0]  edge_src, edge_dst, step_src, step_dst;
  logic [EDGE_CW-1:0] fanin_next;
  dlv_pkg::step_out_t step;
  logic               accept;
  logic               last_node, last_edge, wipe_last, seed_zero;
  logic [CNT_W-1:0]   seeded;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= CNT_W'(MAX_NODES);
    end else if (psel && penable && pwrite && (paddr == dlv_pkg::ADDR_NODE_COUNT)) begin
      node_count_q <= pwdata[CNT_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == dlv_pkg::ADDR_NODE_COUNT) ? 32'(node_count_q) : '0;

  // Clamp the node count to the usable range
  always_comb begin
    if (node_count_q == '0) begin
      n = CNT_W'(1);
    end else if (node_count_q > CNT_W'(MAX_NODES)) begin
      n = CNT_W'(MAX_NODES);
    end else begin
      n = node_count_q;
    end
  end

  // Memories
  dlv_ram #(.WIDTH(2 * NODE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .re_i(edge_re), .raddr_i(edge_raddr), .rdata_o(edge_rdata)
  );

  dlv_ram #(.WIDTH(EDGE_CW), .DEPTH(MAX_NODES)) u_fanin_ram (
    .clk_i, .we_i(fan_we), .waddr_i(fan_waddr), .wdata_i(fan_wdata),
    .re_i(fan_re), .raddr_i(fan_raddr), .rdata_o(fan_rdata)
  );

  dlv_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_fanout_ram (
    .clk_i, .we_i(out_we), .waddr_i(out_waddr), .wdata_i(out_wdata),
    .re_i(out_re), .raddr_i(out_raddr), .rdata_o(out_rdata)
  );

  dlv_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_level_ram (
    .clk_i, .we_i(lev_we), .waddr_i(lev_waddr), .wdata_i(lev_wdata),
    .re_i(lev_re), .raddr_i(lev_raddr), .rdata_o(lev_rdata)
  );

  assign edge_src = edge_rdata[2*NODE_W-1:NODE_W];
  assign edge_dst = edge_rdata[NODE_W-1:0];

  // Shared step unit: checks incoming edges at idle, walks stored edges otherwise
  assign step_src = (state_q == dlv_pkg::ST_IDLE) ? from_node_i : edge_src;
  assign step_dst = (state_q == dlv_pkg::ST_IDLE) ? to_node_i   : edge_dst;

  dlv_step #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_step (
    .relax_i     (state_q == dlv_pkg::ST_REL_C),
    .src_i       (step_src),
    .dst_i       (step_dst),
    .n_i         (n),
    .fanin_i     (fan_rdata),
    .level_src_i (lev_rdata),
    .lvl_i       (lvl_q),
    .fanin_next_o(fanin_next),
    .res_o       (step)
  );

  assign in_ready_o = (state_q == dlv_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign op_in      = dlv_pkg::op_e'(operation_i);
  assign last_node  = ((CNT_W'(idx_q) + CNT_W'(1)) == n);
  assign last_edge  = ((EDGE_CW'(edge_idx_q) + EDGE_CW'(1)) == edge_total_q);
  assign wipe_last  = (idx_q == NODE_W'(MAX_NODES - 1));
  assign seed_zero  = (fan_rdata == '0);
  assign seeded     = next_cnt_q + CNT_W'(seed_zero);

  // State register and datapath registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= dlv_pkg::ST_WIPE;
      op_q         <= dlv_pkg::OP_CLEAR;
      boot_q       <= 1'b1;
      idx_q        <= '0;
      edge_idx_q   <= '0;
      edge_total_q <= '0;
      lvl_q        <= '0;
      next_cnt_q   <= '0;
      levels_q     <= '0;
      sinks_q      <= '0;
      placed_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      op_q         <= op_d;
      boot_q       <= boot_d;
      idx_q        <= idx_d;
      edge_idx_q   <= edge_idx_d;
      edge_total_q <= edge_total_d;
      lvl_q        <= lvl_d;
      next_cnt_q   <= next_cnt_d;
      levels_q     <= levels_d;
      sinks_q      <= sinks_d;
      placed_q     <= placed_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    node_level_q <= node_level_d;
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    boot_d       = boot_q;
    idx_d        = idx_q;
    edge_idx_d   = edge_idx_q;
    edge_total_d = edge_total_q;
    lvl_d        = lvl_q;
    next_cnt_d   = next_cnt_q;
    levels_d     = levels_q;
    sinks_d      = sinks_q;
    placed_d     = placed_q;
    status_d     = status_q;
    node_level_d = node_level_q;
    out_valid_d  = out_valid_q && !out_ready_i;

    edge_we = 1'b0; edge_waddr = edge_total_q[EDGE_AW-1:0];
    edge_wdata = {from_node_i, to_node_i};
    edge_re = 1'b0; edge_raddr = edge_idx_q;
    fan_we = 1'b0; fan_waddr = idx_q; fan_wdata = '0;
    fan_re = 1'b0; fan_raddr = idx_q;
    out_we = 1'b0; out_waddr = idx_q; out_wdata = 1'b0;
    out_re = 1'b0; out_raddr = idx_q;
    lev_we = 1'b0; lev_waddr = idx_q; lev_wdata = NOT_PLACED;
    lev_re = 1'b0; lev_raddr = idx_q;

    case (state_q)
      // Sweep node memories back to empty
      dlv_pkg::ST_WIPE: begin
        lev_we = 1'b1;
        fan_we = 1'b1;
        out_we = 1'b1;
        if (wipe_last) begin
          idx_d = '0;
          if (boot_q) begin
            boot_d  = 1'b0;
            state_d = dlv_pkg::ST_IDLE;
          end else if (op_q == dlv_pkg::OP_LEVELIZE) begin
            state_d = (edge_total_q == '0) ? dlv_pkg::ST_SEED_A : dlv_pkg::ST_CNT_A;
          end else begin
            state_d = dlv_pkg::ST_RESP;
          end
        end else begin
          idx_d = idx_q + NODE_W'(1);
        end
      end

      dlv_pkg::ST_IDLE: begin
        if (accept) begin
          status_d     = dlv_pkg::STAT_OK;
          node_level_d = NOT_PLACED;
          case (op_in)
            dlv_pkg::OP_CLEAR: begin
              edge_total_d = '0;
              levels_d = '0; sinks_d = '0; placed_d = '0;
              op_d  = dlv_pkg::OP_CLEAR;
              idx_d = '0;
              state_d = dlv_pkg::ST_WIPE;
            end
            dlv_pkg::OP_ADD_EDGE: begin
              if (!step.in_range) begin
                status_d = dlv_pkg::STAT_BAD_EDGE;
              end else if (edge_total_q == EDGE_CW'(MAX_EDGES)) begin
                status_d = dlv_pkg::STAT_FULL;
              end else begin
                edge_we      = 1'b1;
                edge_total_d = edge_total_q + EDGE_CW'(1);
              end
              state_d = dlv_pkg::ST_RESP;
            end
            dlv_pkg::OP_LEVELIZE: begin
              levels_d = '0; sinks_d = '0; placed_d = '0;
              op_d       = dlv_pkg::OP_LEVELIZE;
              idx_d      = '0;
              edge_idx_d = '0;
              lvl_d      = '0;
              next_cnt_d = '0;
              state_d    = dlv_pkg::ST_WIPE;
            end
            dlv_pkg::OP_READ: begin
              if (CNT_W'(from_node_i) < n) begin
                lev_re    = 1'b1;
                lev_raddr = from_node_i;
                state_d   = dlv_pkg::ST_READ;
              end else begin
                state_d = dlv_pkg::ST_RESP;
              end
            end
            default: state_d = dlv_pkg::ST_RESP;
          endcase
        end
      end

      dlv_pkg::ST_READ: begin
        node_level_d = lev_rdata;
        state_d      = dlv_pkg::ST_RESP;
      end

      // Count fan-in and mark fan-out from the edge store
      dlv_pkg::ST_CNT_A: begin
        edge_re = 1'b1;
        state_d = dlv_pkg::ST_CNT_B;
      end
      dlv_pkg::ST_CNT_B: begin
        fan_re    = 1'b1;
        fan_raddr = edge_dst;
        state_d   = dlv_pkg::ST_CNT_C;
      end
      dlv_pkg::ST_CNT_C: begin
        if (step.hit) begin
          fan_we    = 1'b1;
          fan_waddr = edge_dst;
          fan_wdata = fanin_next;
          out_we    = 1'b1;
          out_waddr = edge_src;
          out_wdata = 1'b1;
        end
        if (last_edge) begin
          edge_idx_d = '0;
          state_d    = dlv_pkg::ST_SEED_A;
        end else begin
          edge_idx_d = edge_idx_q + EDGE_AW'(1);
          state_d    = dlv_pkg::ST_CNT_A;
        end
      end

      // Place sources at level 0 and count sinks
      dlv_pkg::ST_SEED_A: begin
        fan_re  = 1'b1;
        out_re  = 1'b1;
        state_d = dlv_pkg::ST_SEED_B;
      end
      dlv_pkg::ST_SEED_B: begin
        if (seed_zero) begin
          lev_we     = 1'b1;
          lev_wdata  = '0;
          next_cnt_d = seeded;
          placed_d   = placed_q + CNT_W'(1);
        end
        if (!out_rdata) begin
          sinks_d = sinks_q + CNT_W'(1);
        end
        if (last_node) begin
          idx_d = '0;
          if (seeded == '0) begin
            state_d = dlv_pkg::ST_FIN;
          end else begin
            next_cnt_d = '0;
            state_d = (edge_total_q == '0) ? dlv_pkg::ST_LVL_END : dlv_pkg::ST_REL_A;
          end
        end else begin
          idx_d   = idx_q + NODE_W'(1);
          state_d = dlv_pkg::ST_SEED_A;
        end
      end

      // Use up fan-in of edges leaving the current level
      dlv_pkg::ST_REL_A: begin
        edge_re = 1'b1;
        state_d = dlv_pkg::ST_REL_B;
      end
      dlv_pkg::ST_REL_B: begin
        lev_re    = 1'b1;
        lev_raddr = edge_src;
        fan_re    = 1'b1;
        fan_raddr = edge_dst;
        state_d   = dlv_pkg::ST_REL_C;
      end
      dlv_pkg::ST_REL_C: begin
        if (step.hit) begin
          fan_we    = 1'b1;
          fan_waddr = edge_dst;
          fan_wdata = fanin_next;
        end
        if (step.placed) begin
          lev_we     = 1'b1;
          lev_waddr  = edge_dst;
          lev_wdata  = lvl_q + CNT_W'(1);
          next_cnt_d = next_cnt_q + CNT_W'(1);
          placed_d   = placed_q + CNT_W'(1);
        end
        if (last_edge) begin
          edge_idx_d = '0;
          state_d    = dlv_pkg::ST_LVL_END;
        end else begin
          edge_idx_d = edge_idx_q + EDGE_AW'(1);
          state_d    = dlv_pkg::ST_REL_A;
        end
      end

      // Close one level, continue while the next one is non-empty
      dlv_pkg::ST_LVL_END: begin
        levels_d   = levels_q + CNT_W'(1);
        lvl_d      = lvl_q + CNT_W'(1);
        next_cnt_d = '0;
        state_d    = (next_cnt_q == '0) ? dlv_pkg::ST_FIN : dlv_pkg::ST_REL_A;
      end

      dlv_pkg::ST_FIN: begin
        status_d = (placed_q < n) ? dlv_pkg::STAT_CYCLE : dlv_pkg::STAT_OK;
        state_d  = dlv_pkg::ST_RESP;
      end

      dlv_pkg::ST_RESP: begin
        out_valid_d = 1'b1;
        state_d     = dlv_pkg::ST_IDLE;
      end

      default: state_d = dlv_pkg::ST_IDLE;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign node_level_o   = node_level_q;
  assign level_total_o  = levels_q;
  assign sink_total_o   = sinks_q;
  assign placed_total_o = placed_q;

endmodule

/* design/dlv_checker.sv */
`timescale 1ns / 1ps

module dlv_checker #(
  parameter int unsigned MAX_NODES = dlv_pkg::MAX_NODES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_NODES + 1)
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [1:0]       status_o,
  input logic [CNT_W-1:0] node_level_o,
  input logic [CNT_W-1:0] level_total_o,
  input logic [CNT_W-1:0] placed_total_o
);

  // A result held back keeps its status
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o))
    else $error("result changed while stalled");

  // No result shows in the cycle after an item is taken
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !out_valid_o)
    else $error("result appeared too early");

  // A stalled result blocks new items
  a_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken while result stalled");

  // A placed level only comes with an ok status
  a_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (node_level_o != CNT_W'(MAX_NODES)) |-> status_o == dlv_pkg::STAT_OK)
    else $error("level reported with error status");

  // Every level holds at least one placed node
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_total_o <= placed_total_o)
    else $error("more levels than placed nodes");

endmodule

bind dag_levelizer dlv_checker #(.MAX_NODES(MAX_NODES)) u_dlv_checker (.*);
